### design/bdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque package
// Shared widths, request codes, error codes and controller states.
// ----------------------------------------------------------------------------
package bdq_pkg;

  // Fixed field widths of the request and result transactions
  localparam int unsigned OP_W    = 3;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned ERR_W   = 2;

  // Default storage shape
  localparam int unsigned DefaultDepth     = 16;
  localparam int unsigned DefaultDataWidth = 32;

  // Request codes; the two codes above clear do nothing
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_READ_AT    = 3'd3,
    OP_WRITE_AT   = 3'd4,
    OP_CLEAR      = 3'd5
  } op_e;

  // Result error codes
  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2,
    ERR_RANGE = 2'd3
  } err_e;

  // Controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_e;

endpackage

### design/bdq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque channel interfaces
// Request channel (op, position, value) and result channel, valid/ready.
// ----------------------------------------------------------------------------
interface bdq_req_if #(
  parameter int unsigned DATA_WIDTH = bdq_pkg::DefaultDataWidth
);
  logic                           valid;
  logic                           ready;
  logic [bdq_pkg::OP_W-1:0]       op;
  logic [bdq_pkg::POS_W-1:0]      position;
  logic signed [DATA_WIDTH-1:0]   value;

  modport source (output valid, output op, output position, output value, input ready);
  modport sink   (input valid, input op, input position, input value, output ready);
endinterface

interface bdq_rsp_if #(
  parameter int unsigned DATA_WIDTH = bdq_pkg::DefaultDataWidth
);
  logic                           valid;
  logic                           ready;
  logic signed [DATA_WIDTH-1:0]   read_value;
  logic signed [DATA_WIDTH-1:0]   front_value;
  logic signed [DATA_WIDTH-1:0]   back_value;
  logic [bdq_pkg::COUNT_W-1:0]    count;
  logic                           empty_res;
  logic [bdq_pkg::ERR_W-1:0]      error;

  modport source (
    output valid, output read_value, output front_value, output back_value,
    output count, output empty_res, output error, input ready
  );
  modport sink (
    input valid, input read_value, input front_value, input back_value,
    input count, input empty_res, input error, output ready
  );
endinterface

### design/bdq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque ring store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bdq_ram #(
  parameter int unsigned DEPTH      = bdq_pkg::DefaultDepth,
  parameter int unsigned DATA_WIDTH = bdq_pkg::DefaultDataWidth
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [$clog2(DEPTH)-1:0]  waddr_i,
  input  logic [DATA_WIDTH-1:0]     wdata_i,
  input  logic                      re_i,
  input  logic [$clog2(DEPTH)-1:0]  raddr_i,
  output logic [DATA_WIDTH-1:0]     rdata_o
);

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data registered and valid in the cycle after the request
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/bdq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque controller
// Head pointer, count, cached front/back words, store access and result reg.
// ----------------------------------------------------------------------------
module bdq_ctrl #(
  parameter int unsigned DEPTH      = bdq_pkg::DefaultDepth,
  parameter int unsigned DATA_WIDTH = bdq_pkg::DefaultDataWidth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  bdq_req_if.sink                   req_i,
  bdq_rsp_if.source                 rsp_o,
  output logic                      mem_we_o,
  output logic [$clog2(DEPTH)-1:0]  mem_waddr_o,
  output logic [DATA_WIDTH-1:0]     mem_wdata_o,
  output logic                      mem_re_o,
  output logic [$clog2(DEPTH)-1:0]  mem_raddr_o,
  input  logic [DATA_WIDTH-1:0]     mem_rdata_i
);
  import bdq_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W = PTR_W + 1;
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Slot of head plus an offset below DEPTH, folded back into the ring
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                input logic [SUM_W-1:0] offs);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + offs;
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  state_e                state_q, state_d;
  logic [PTR_W-1:0]      head_q, head_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [DATA_WIDTH-1:0] front_q, front_d;
  logic [DATA_WIDTH-1:0] back_q, back_d;
  logic                  rd_at_q, rd_at_d;

  logic                  out_valid_q, out_valid_d;
  logic [DATA_WIDTH-1:0] out_read_q, out_read_d;
  logic [DATA_WIDTH-1:0] out_front_q, out_front_d;
  logic [DATA_WIDTH-1:0] out_back_q, out_back_d;
  logic [CNT_W-1:0]      out_count_q, out_count_d;
  err_e                  out_err_q, out_err_d;

  logic                  accept;
  logic                  is_full;
  logic                  is_empty;
  logic                  pos_ok;
  logic                  pos_last;
  logic [DATA_WIDTH-1:0] in_value;

  assign in_value = DATA_WIDTH'(req_i.value);
  assign is_full  = (count_q == CNT_W'(DEPTH));
  assign is_empty = (count_q == '0);
  assign pos_ok   = (CMP_W'(req_i.position) < CMP_W'(count_q));
  assign pos_last = (CMP_W'(req_i.position) == (CMP_W'(count_q) - CMP_W'(1)));

  // Take a request only when idle and the result register is free or draining
  assign req_i.ready = (state_q == ST_IDLE) && (!out_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;

  // Next state, store access and result load
  always_comb begin
    logic                  load;
    logic [DATA_WIDTH-1:0] res_read;
    err_e                  res_err;

    load        = 1'b0;
    res_read    = '0;
    res_err     = ERR_NONE;
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    front_d     = front_q;
    back_d      = back_q;
    rd_at_d     = rd_at_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = in_value;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          load = 1'b1;
          unique case (op_e'(req_i.op))
            OP_PUSH_BACK: begin
              if (is_full) begin
                res_err = ERR_FULL;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = wrap_add(head_q, SUM_W'(count_q));
                count_d     = count_q + CNT_W'(1);
                back_d      = in_value;
                if (is_empty) begin
                  front_d = in_value;
                end
              end
            end
            OP_PUSH_FRONT: begin
              if (is_full) begin
                res_err = ERR_FULL;
              end else begin
                head_d      = (head_q == '0) ? PTR_W'(DEPTH - 1) : head_q - PTR_W'(1);
                mem_we_o    = 1'b1;
                mem_waddr_o = head_d;
                count_d     = count_q + CNT_W'(1);
                front_d     = in_value;
                if (is_empty) begin
                  back_d = in_value;
                end
              end
            end
            OP_POP_FRONT: begin
              if (is_empty) begin
                res_err = ERR_EMPTY;
              end else begin
                // Advance head and fetch the new front word
                head_d      = wrap_add(head_q, SUM_W'(1));
                count_d     = count_q - CNT_W'(1);
                mem_re_o    = 1'b1;
                mem_raddr_o = head_d;
                rd_at_d     = 1'b0;
                state_d     = ST_READ;
                load        = 1'b0;
              end
            end
            OP_READ_AT: begin
              if (!pos_ok) begin
                res_err = ERR_RANGE;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = wrap_add(head_q, SUM_W'(req_i.position));
                rd_at_d     = 1'b1;
                state_d     = ST_READ;
                load        = 1'b0;
              end
            end
            OP_WRITE_AT: begin
              if (!pos_ok) begin
                res_err = ERR_RANGE;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = wrap_add(head_q, SUM_W'(req_i.position));
                if (req_i.position == '0) begin
                  front_d = in_value;
                end
                if (pos_last) begin
                  back_d = in_value;
                end
              end
            end
            OP_CLEAR: begin
              head_d  = '0;
              count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        // Finish the pending store read
        load    = 1'b1;
        state_d = ST_IDLE;
        if (rd_at_q) begin
          res_read = mem_rdata_i;
        end else begin
          front_d = mem_rdata_i;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Result register: drop when taken, load on completion
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_read_d  = out_read_q;
    out_front_d = out_front_q;
    out_back_d  = out_back_q;
    out_count_d = out_count_q;
    out_err_d   = out_err_q;
    if (load) begin
      out_valid_d = 1'b1;
      out_read_d  = res_read;
      out_count_d = count_d;
      out_err_d   = res_err;
      out_front_d = (count_d == '0) ? '0 : front_d;
      out_back_d  = (count_d == '0) ? '0 : back_d;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      rd_at_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      rd_at_q     <= rd_at_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Cached words and result payload
  always_ff @(posedge clk_i) begin
    front_q     <= front_d;
    back_q      <= back_d;
    out_read_q  <= out_read_d;
    out_front_q <= out_front_d;
    out_back_q  <= out_back_d;
    out_count_q <= out_count_d;
    out_err_q   <= out_err_d;
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.read_value  = out_read_q;
  assign rsp_o.front_value = out_front_q;
  assign rsp_o.back_value  = out_back_q;
  assign rsp_o.count       = COUNT_W'(out_count_q);
  assign rsp_o.empty_res   = (out_count_q == '0);
  assign rsp_o.error       = out_err_q;

endmodule

### design/bounded_deque_with_indexed_access_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque with indexed access
// Ring-buffer double-ended queue with push, pop, indexed read/write, clear.
// ----------------------------------------------------------------------------
//  Channel  | Dir | Handshake      | Payload
//  ---------+-----+----------------+------------------------------------------
//  req_i    | in  | valid / ready  | op, position, value
//  rsp_o    | out | valid / ready  | read_value, front_value, back_value,
//           |     |                | count, empty_res, error
//
// Pushes, indexed writes, clear and rejected requests load the result at once;
// pop and indexed read pass through the read state for the store's registered read.
// One transaction is in flight at a time; the result register frees the
// request side as soon as it is being drained.
// Reset clears head pointer and count; store contents are not cleared.
// A stalled result holds req_i.ready low until rsp_o.ready frees the register.
// ----------------------------------------------------------------------------
module bounded_deque_with_indexed_access_top #(
  parameter int unsigned DEPTH      = bdq_pkg::DefaultDepth,
  parameter int unsigned DATA_WIDTH = bdq_pkg::DefaultDataWidth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bdq_req_if.sink    req_i,
  bdq_rsp_if.source  rsp_o
);

  logic                      mem_we;
  logic [$clog2(DEPTH)-1:0]  mem_waddr;
  logic [DATA_WIDTH-1:0]     mem_wdata;
  logic                      mem_re;
  logic [$clog2(DEPTH)-1:0]  mem_raddr;
  logic [DATA_WIDTH-1:0]     mem_rdata;

  // Pointer and result control
  bdq_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // Ring store
  bdq_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule
